// ===== hw/rtl/olee_pkg.sv =====
// olee_pkg: shared types and codes for the ordered list edit engine
// transaction structs, request and status codes, controller states
// no dependencies
package olee_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_OUT_W = 6;

    localparam logic [2:0] REQ_APPEND     = 3'd0;
    localparam logic [2:0] REQ_COUNT      = 3'd1;
    localparam logic [2:0] REQ_REMOVE_ALL = 3'd2;
    localparam logic [2:0] REQ_REMOVE_AFT = 3'd3;
    localparam logic [2:0] REQ_INS_AFTER  = 3'd4;
    localparam logic [2:0] REQ_INS_BEFORE = 3'd5;
    localparam logic [2:0] REQ_CLEAR      = 3'd6;
    localparam logic [2:0] REQ_DUMP       = 3'd7;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [VAL_W-1:0] key;
        logic signed [VAL_W-1:0] new_value;
    } in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] match_count;
        logic signed [VAL_W-1:0] entry_value;
        logic                 last;
    } out_t;

    typedef struct packed {
        logic pop;
        logic push;
    } shift_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_REPLY
    } state_t;

endpackage

// ===== hw/rtl/olee_cell.sv =====
// olee_cell: one list entry of the chain
// takes its right neighbor on a shift or the tail write value when addressed
// depends on olee_pkg
module olee_cell (
    input  logic                             clk,
    input  logic                             shift_en,
    input  logic                             wr_en,
    input  logic [olee_pkg::VAL_W-1:0]       wr_val,
    input  logic [olee_pkg::VAL_W-1:0]       right_val,
    output logic [olee_pkg::VAL_W-1:0]       val
);

    logic [olee_pkg::VAL_W-1:0] val_reg;
    logic [olee_pkg::VAL_W-1:0] val_next;

    always_comb
    begin
        if (wr_en)
        begin
            val_next = wr_val;
        end
        else if (shift_en)
        begin
            val_next = right_val;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== hw/rtl/olee_ctrl.sv =====
// olee_ctrl: request sequencer for the ordered list edit engine
// walks the list through the head cell, drives pop and tail push, holds the output register
// depends on olee_pkg
module olee_ctrl #(
    parameter int LIST_DEPTH = 32,
    parameter int CNT_W      = 6,
    parameter int IDX_W      = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  olee_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output olee_pkg::out_t              out_data,
    input  logic [olee_pkg::VAL_W-1:0]  head_val,
    output olee_pkg::shift_cmd_t        cmd,
    output logic [IDX_W-1:0]            wr_idx,
    output logic [olee_pkg::VAL_W-1:0]  wr_val
);

    olee_pkg::state_t state_reg, state_next;
    logic [2:0]                 req_reg, req_next;
    logic [olee_pkg::VAL_W-1:0] key_reg, key_next;
    logic [olee_pkg::VAL_W-1:0] nv_reg, nv_next;
    logic [CNT_W-1:0]           len_reg, len_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [1:0]                 status_reg, status_next;
    logic                       found_reg, found_next;
    logic                       pend_reg, pend_next;
    logic                       flag_reg, flag_next;
    logic                       tail_reg, tail_next;
    logic                       out_valid_reg, out_valid_next;
    olee_pkg::out_t             out_data_reg, out_data_next;

    logic           out_free;
    logic           is_insert;
    logic           is_dump;
    logic           full;
    logic           match;
    logic           scan_busy;
    logic           emit;
    olee_pkg::out_t emit_data;
    logic           pop;
    logic           push;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_insert = (req_reg == olee_pkg::REQ_INS_AFTER) ||
                       (req_reg == olee_pkg::REQ_INS_BEFORE);
    assign is_dump   = (req_reg == olee_pkg::REQ_DUMP);
    assign full      = (len_reg == CNT_W'(LIST_DEPTH));
    assign match     = (head_val == key_reg);
    assign scan_busy = (rem_reg != '0) || pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olee_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = olee_pkg::ST_START;
                end
            end
            olee_pkg::ST_START:
            begin
                case (req_reg)
                    olee_pkg::REQ_APPEND,
                    olee_pkg::REQ_CLEAR:
                    begin
                        state_next = olee_pkg::ST_REPLY;
                    end
                    olee_pkg::REQ_INS_AFTER,
                    olee_pkg::REQ_INS_BEFORE:
                    begin
                        state_next = full ? olee_pkg::ST_REPLY : olee_pkg::ST_SCAN;
                    end
                    olee_pkg::REQ_DUMP:
                    begin
                        state_next = (len_reg == '0) ? olee_pkg::ST_REPLY
                                                     : olee_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = olee_pkg::ST_SCAN;
                    end
                endcase
            end
            olee_pkg::ST_SCAN:
            begin
                if (!scan_busy)
                begin
                    state_next = is_dump ? olee_pkg::ST_IDLE : olee_pkg::ST_REPLY;
                end
            end
            olee_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = olee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = olee_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next    = req_reg;
        key_next    = key_reg;
        nv_next     = nv_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        found_next  = found_reg;
        pend_next   = pend_reg;
        flag_next   = flag_reg;
        tail_next   = tail_reg;
        pop         = 1'b0;
        push        = 1'b0;
        emit        = 1'b0;
        emit_data   = '0;
        in_ready    = 1'b0;

        case (state_reg)
            olee_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next = in_data.req_type;
                    key_next = in_data.key;
                    nv_next  = in_data.new_value;
                end
            end
            olee_pkg::ST_START:
            begin
                rem_next    = len_reg;
                cnt_next    = '0;
                found_next  = 1'b0;
                pend_next   = 1'b0;
                flag_next   = 1'b0;
                tail_next   = 1'b0;
                status_next = olee_pkg::STAT_OK;
                case (req_reg)
                    olee_pkg::REQ_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = olee_pkg::STAT_FULL;
                        end
                        else
                        begin
                            tail_next = 1'b1;
                        end
                    end
                    olee_pkg::REQ_CLEAR:
                    begin
                        cnt_next = len_reg;
                        len_next = '0;
                    end
                    olee_pkg::REQ_INS_AFTER,
                    olee_pkg::REQ_INS_BEFORE:
                    begin
                        if (full)
                        begin
                            status_next = olee_pkg::STAT_FULL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            olee_pkg::ST_SCAN:
            begin
                if (!scan_busy)
                begin
                    if (is_insert && !found_reg)
                    begin
                        tail_next   = 1'b1;
                        status_next = olee_pkg::STAT_NOT_FOUND;
                    end
                end
                else if (!(is_dump && !out_free))
                begin
                    if (pend_reg)
                    begin
                        // insert after: new value follows the match just pushed
                        push      = 1'b1;
                        pend_next = 1'b0;
                    end
                    else if (req_reg == olee_pkg::REQ_INS_BEFORE && !found_reg && match)
                    begin
                        push       = 1'b1;
                        found_next = 1'b1;
                    end
                    else
                    begin
                        pop      = 1'b1;
                        rem_next = rem_reg - 1'b1;
                        case (req_reg)
                            olee_pkg::REQ_COUNT:
                            begin
                                push = 1'b1;
                                if (match)
                                begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                            olee_pkg::REQ_REMOVE_ALL:
                            begin
                                push = !match;
                                if (match)
                                begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                            olee_pkg::REQ_REMOVE_AFT:
                            begin
                                if (flag_reg)
                                begin
                                    cnt_next  = cnt_reg + 1'b1;
                                    flag_next = 1'b0;
                                end
                                else
                                begin
                                    push      = 1'b1;
                                    flag_next = match;
                                end
                            end
                            olee_pkg::REQ_INS_AFTER,
                            olee_pkg::REQ_INS_BEFORE:
                            begin
                                push = 1'b1;
                                if (!found_reg && match)
                                begin
                                    found_next = 1'b1;
                                    pend_next  = (req_reg == olee_pkg::REQ_INS_AFTER);
                                end
                            end
                            olee_pkg::REQ_DUMP:
                            begin
                                push                  = 1'b1;
                                emit                  = 1'b1;
                                emit_data.entry_value = head_val;
                                emit_data.last        = (rem_reg == CNT_W'(1));
                            end
                            default:
                            begin
                                push = 1'b1;
                            end
                        endcase
                    end
                end
            end
            olee_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_data.status      = status_reg;
                    emit_data.match_count = olee_pkg::CNT_OUT_W'(cnt_reg);
                    emit_data.last        = 1'b1;
                    if (tail_reg)
                    begin
                        push = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (pop || push)
        begin
            len_next = len_reg - CNT_W'(pop) + CNT_W'(push);
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cmd.pop   = pop;
    assign cmd.push  = push;
    assign wr_idx    = IDX_W'(len_reg - CNT_W'(pop));
    // a rotation moves the head to the tail, otherwise the new value goes in
    assign wr_val    = pop ? head_val : nv_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olee_pkg::ST_IDLE;
            len_reg       <= '0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            flag_reg      <= flag_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        nv_reg       <= nv_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/ordered_list_edit_engine.sv =====
// ordered_list_edit_engine: top level, a chain of entry cells and its sequencer
// depends on olee_pkg, olee_cell, olee_ctrl
//
// Keeps an ordered list of up to LIST_DEPTH signed 32-bit entries in a chain of
// cells and serves one request per input transaction. Append, clear, an insert
// into a full list and a dump of an empty list skip the scan and wait only for
// the output register. Count, both removals and insert stream the whole list once
// through the head cell, one entry per cycle, with one extra step when an insert
// finds its match; dump streams it the same way, delivers one output transaction
// per entry and slows down when out_ready is low. A new request is taken only
// after the previous one has finished.
module ordered_list_edit_engine #(
    parameter int LIST_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  olee_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output olee_pkg::out_t out_data
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);

    logic [olee_pkg::VAL_W-1:0] cell_val [LIST_DEPTH];
    olee_pkg::shift_cmd_t       cmd;
    logic [IDX_W-1:0]           wr_idx;
    logic [olee_pkg::VAL_W-1:0] wr_val;

    olee_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head_val  (cell_val[0]),
        .cmd       (cmd),
        .wr_idx    (wr_idx),
        .wr_val    (wr_val)
    );

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [olee_pkg::VAL_W-1:0] right_val;

        if (i == LIST_DEPTH - 1)
        begin : g_end
            assign right_val = cell_val[i];
        end
        else
        begin : g_mid
            assign right_val = cell_val[i + 1];
        end

        olee_cell u_cell (
            .clk       (clk),
            .shift_en  (cmd.pop),
            .wr_en     (cmd.push && (wr_idx == IDX_W'(i))),
            .wr_val    (wr_val),
            .right_val (right_val),
            .val       (cell_val[i])
        );
    end

endmodule

// ===== sim/ordered_list_edit_engine_tb.sv =====
// ordered_list_edit_engine_tb: self-checking testbench for the ordered list edit engine
// holds a scoreboard class that tracks the list contents and predicts every result
// depends on olee_pkg and ordered_list_edit_engine
module ordered_list_edit_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam logic [olee_pkg::VAL_W-1:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [olee_pkg::VAL_W-1:0] VMIN = 32'h8000_0000;
    localparam logic [olee_pkg::VAL_W-1:0] VNEG = 32'hFFFF_FFFF;

    class list_scoreboard;
        logic [olee_pkg::VAL_W-1:0] vals [DEPTH];
        int unsigned                fill;
        olee_pkg::out_t             expected_q [$];
        int                         errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function void expect_result(logic [1:0] st, int unsigned cnt,
                                    logic [olee_pkg::VAL_W-1:0] v, logic lst);
            olee_pkg::out_t r;
            r.status      = st;
            r.match_count = olee_pkg::CNT_OUT_W'(cnt);
            r.entry_value = v;
            r.last        = lst;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void drop_at(int unsigned pos);
            int unsigned j;
            for (j = pos; j + 1 < fill; j++)
                vals[j] = vals[j + 1];
            fill--;
        endfunction

        function void place_at(int unsigned pos, logic [olee_pkg::VAL_W-1:0] v);
            int unsigned j;
            for (j = fill; j > pos; j--)
                vals[j] = vals[j - 1];
            vals[pos] = v;
            fill++;
        endfunction

        function void note_request(olee_pkg::in_t req);
            int unsigned i;
            int unsigned cnt;
            int unsigned pos;
            bit          found;
            cnt = 0;
            found = 1'b0;
            pos = 0;
            case (req.req_type)
                olee_pkg::REQ_APPEND:
                begin
                    if (fill >= DEPTH)
                        expect_result(olee_pkg::STAT_FULL, 0, '0, 1'b1);
                    else
                    begin
                        vals[fill] = req.new_value;
                        fill++;
                        expect_result(olee_pkg::STAT_OK, 0, '0, 1'b1);
                    end
                end
                olee_pkg::REQ_COUNT:
                begin
                    for (i = 0; i < fill; i++)
                        if (vals[i] == req.key)
                            cnt++;
                    expect_result(olee_pkg::STAT_OK, cnt, '0, 1'b1);
                end
                olee_pkg::REQ_REMOVE_ALL:
                begin
                    i = 0;
                    while (i < fill)
                    begin
                        if (vals[i] == req.key)
                        begin
                            drop_at(i);
                            cnt++;
                        end
                        else
                            i++;
                    end
                    expect_result(olee_pkg::STAT_OK, cnt, '0, 1'b1);
                end
                olee_pkg::REQ_REMOVE_AFT:
                begin
                    // successor removed, then the new successor is tested
                    for (i = 0; i < fill; i++)
                    begin
                        if (vals[i] == req.key && i + 1 < fill)
                        begin
                            drop_at(i + 1);
                            cnt++;
                        end
                    end
                    expect_result(olee_pkg::STAT_OK, cnt, '0, 1'b1);
                end
                olee_pkg::REQ_INS_AFTER, olee_pkg::REQ_INS_BEFORE:
                begin
                    if (fill >= DEPTH)
                        expect_result(olee_pkg::STAT_FULL, 0, '0, 1'b1);
                    else
                    begin
                        for (i = 0; i < fill && !found; i++)
                        begin
                            if (vals[i] == req.key)
                            begin
                                found = 1'b1;
                                pos = (req.req_type == olee_pkg::REQ_INS_AFTER) ? i + 1 : i;
                            end
                        end
                        if (!found)
                            pos = fill;
                        place_at(pos, req.new_value);
                        expect_result(found ? olee_pkg::STAT_OK : olee_pkg::STAT_NOT_FOUND,
                                      0, '0, 1'b1);
                    end
                end
                olee_pkg::REQ_CLEAR:
                begin
                    cnt = fill;
                    fill = 0;
                    expect_result(olee_pkg::STAT_OK, cnt, '0, 1'b1);
                end
                olee_pkg::REQ_DUMP:
                begin
                    if (fill == 0)
                        expect_result(olee_pkg::STAT_OK, 0, '0, 1'b1);
                    else
                        for (i = 0; i < fill; i++)
                            expect_result(olee_pkg::STAT_OK, 0, vals[i], i + 1 == fill);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(olee_pkg::out_t got);
            olee_pkg::out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("unexpected result: status %0d match_count %0d entry_value %0d last %0d",
                       got.status, got.match_count, got.entry_value, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.match_count !== want.match_count)
            begin
                errors++;
                $error("match_count: expected %0d, got %0d",
                       want.match_count, got.match_count);
            end
            if (got.entry_value !== want.entry_value)
            begin
                errors++;
                $error("entry_value: expected %0d, got %0d",
                       want.entry_value, got.entry_value);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $error("last: expected %0d, got %0d", want.last, got.last);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    olee_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    olee_pkg::out_t out_data;

    list_scoreboard sb = new();

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int sent     = 0;

    ordered_list_edit_engine #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("ordered_list_edit_engine regression: fail");
        $finish;
    end

    // result side: check each transaction, random stalls, long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    function automatic olee_pkg::in_t make_req(logic [2:0] op,
                                               logic [olee_pkg::VAL_W-1:0] k,
                                               logic [olee_pkg::VAL_W-1:0] v);
        olee_pkg::in_t r;
        r.req_type  = op;
        r.key       = k;
        r.new_value = v;
        return r;
    endfunction

    function automatic logic [olee_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'h0000_0003;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return olee_pkg::REQ_APPEND;
        if (r < 40) return olee_pkg::REQ_COUNT;
        if (r < 50) return olee_pkg::REQ_REMOVE_ALL;
        if (r < 60) return olee_pkg::REQ_REMOVE_AFT;
        if (r < 70) return olee_pkg::REQ_INS_AFTER;
        if (r < 80) return olee_pkg::REQ_INS_BEFORE;
        if (r < 84) return olee_pkg::REQ_CLEAR;
        return olee_pkg::REQ_DUMP;
    endfunction

    task automatic send_request(olee_pkg::in_t req);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic fill_list(bit with_hold);
        while (sb.fill < DEPTH)
            send_request(make_req(olee_pkg::REQ_APPEND, pick_value(), pick_value()));
        send_request(make_req(olee_pkg::REQ_APPEND, pick_value(), pick_value()));
        send_request(make_req(olee_pkg::REQ_INS_AFTER, sb.vals[0], pick_value()));
        send_request(make_req(olee_pkg::REQ_INS_BEFORE, 32'h1234_5678, pick_value()));
        if (with_hold)
            hold_req = 1'b1;
        send_request(make_req(olee_pkg::REQ_DUMP, pick_value(), pick_value()));
        send_request(make_req(olee_pkg::REQ_COUNT, sb.vals[DEPTH-1], pick_value()));
        send_request(make_req(olee_pkg::REQ_REMOVE_AFT, sb.vals[DEPTH-1], pick_value()));
        send_request(make_req(olee_pkg::REQ_REMOVE_ALL, sb.vals[0], pick_value()));
    endtask

    task automatic run_directed();
        // empty list corners
        send_request(make_req(olee_pkg::REQ_DUMP, '0, '0));
        send_request(make_req(olee_pkg::REQ_COUNT, '0, '0));
        send_request(make_req(olee_pkg::REQ_REMOVE_ALL, '0, '0));
        send_request(make_req(olee_pkg::REQ_REMOVE_AFT, '0, '0));
        send_request(make_req(olee_pkg::REQ_CLEAR, '0, '0));
        // inserts with no match go to the tail
        send_request(make_req(olee_pkg::REQ_INS_AFTER, VMAX, 32'd11));
        send_request(make_req(olee_pkg::REQ_INS_BEFORE, VMIN, 32'd12));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMAX));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMIN));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VNEG));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMAX));
        send_request(make_req(olee_pkg::REQ_COUNT, VMAX, '0));
        send_request(make_req(olee_pkg::REQ_INS_AFTER, VMIN, 32'd5));
        send_request(make_req(olee_pkg::REQ_INS_BEFORE, VMIN, 32'd7));
        // match at the tail has no successor
        send_request(make_req(olee_pkg::REQ_REMOVE_AFT, VMAX, '0));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMAX));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMAX));
        send_request(make_req(olee_pkg::REQ_APPEND, '0, VMAX));
        // run of equal values, no entry skipped
        send_request(make_req(olee_pkg::REQ_REMOVE_AFT, VMAX, '0));
        send_request(make_req(olee_pkg::REQ_DUMP, '0, '0));
        send_request(make_req(olee_pkg::REQ_REMOVE_ALL, VNEG, '0));
        send_request(make_req(olee_pkg::REQ_DUMP, '0, '0));
        send_request(make_req(olee_pkg::REQ_CLEAR, '0, '0));
        send_request(make_req(olee_pkg::REQ_DUMP, '0, '0));
    endtask

    initial
    begin
        int  r;
        int  n;
        bit  paused;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        run_directed();
        drain();
        fill_list(1'b1);
        while (sent < 150)
        begin
            calm = (sent >= 60 && sent < 100);
            r = $urandom_range(0, 99);
            n = $urandom_range(4, 12);
            if (r < 6)
                fill_list(1'b0);
            else if (r < 20)
                repeat (n)
                    send_request(make_req(3'($urandom), $urandom, $urandom));
            else
                repeat (n)
                    send_request(make_req(pick_op(), pick_value(), pick_value()));
            if (!paused && sent >= 100)
            begin
                calm = 1'b0;
                drain();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
        drain();
        if (sb.errors == 0)
            $display("ordered_list_edit_engine regression: pass");
        else
            $display("ordered_list_edit_engine regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/olee_pkg.sv
hw/rtl/olee_cell.sv
hw/rtl/olee_ctrl.sv
hw/rtl/ordered_list_edit_engine.sv
sim/ordered_list_edit_engine_tb.sv
